/* design/rgb2yuv_pkg.sv */
// Shared types and constants for the RGB to YUV 4:2:0 pixel converter.
// No dependencies.
`timescale 1ns / 1ps

package rgb2yuv_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 13'd256;

  typedef struct packed {
    logic even_col;
    logic odd_row;
    logic end_of_frame;
  } pos_t;

endpackage

/* design/rgb2yuv_pos.sv */
// Column and row counters of the pixel stream, with frame size clamping.
// Depends on rgb2yuv_pkg.
`timescale 1ns / 1ps

module rgb2yuv_pos #(
  parameter int MAX_WIDTH  = rgb2yuv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgb2yuv_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rgb2yuv_pkg::CFG_W-1:0] frame_width_i,
  input  logic [rgb2yuv_pkg::CFG_W-1:0] frame_height_i,
  input  logic                          advance_i,
  output rgb2yuv_pkg::pos_t             pos_o
);
  import rgb2yuv_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int LCW   = (COL_W > CFG_W) ? COL_W : CFG_W;
  localparam int LRW   = (ROW_W > CFG_W) ? ROW_W : CFG_W;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [LCW-1:0]   col_last;
  logic [LRW-1:0]   row_last;
  logic             at_last_col;
  logic             at_last_row;

  always_comb begin
    if (frame_width_i < CFG_W'(2)) begin
      col_last = LCW'(1);
    end else if (32'(frame_width_i) > 32'(MAX_WIDTH)) begin
      col_last = LCW'(MAX_WIDTH - 1);
    end else begin
      col_last = LCW'(frame_width_i) - LCW'(1);
    end
    if (frame_height_i < CFG_W'(2)) begin
      row_last = LRW'(1);
    end else if (32'(frame_height_i) > 32'(MAX_HEIGHT)) begin
      row_last = LRW'(MAX_HEIGHT - 1);
    end else begin
      row_last = LRW'(frame_height_i) - LRW'(1);
    end
  end

  assign at_last_col = LCW'(col_q) >= col_last;
  assign at_last_row = LRW'(row_q) >= row_last;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (at_last_col) begin
        col_d = '0;
        row_d = at_last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.even_col     = ~col_q[0];
  assign pos_o.odd_row      = row_q[0];
  assign pos_o.end_of_frame = at_last_col & at_last_row;

endmodule

/* design/rgb2yuv_csc.sv */
// BT.601 limited-range color space conversion of one pixel, integer math.
// Depends on rgb2yuv_pkg.
`timescale 1ns / 1ps

module rgb2yuv_csc (
  input  logic [rgb2yuv_pkg::PIX_W-1:0] red_i,
  input  logic [rgb2yuv_pkg::PIX_W-1:0] green_i,
  input  logic [rgb2yuv_pkg::PIX_W-1:0] blue_i,
  input  rgb2yuv_pkg::pos_t             pos_i,
  output logic [rgb2yuv_pkg::PIX_W-1:0] luma_o,
  output logic                          chroma_valid_o,
  output logic                          chroma_is_v_o,
  output logic [rgb2yuv_pkg::PIX_W-1:0] chroma_o
);
  import rgb2yuv_pkg::*;

  logic [15:0] r16, g16, b16;
  logic [15:0] y_sum, u_sum, v_sum;

  assign r16 = 16'(red_i);
  assign g16 = 16'(green_i);
  assign b16 = 16'(blue_i);

  // offset 128*256 + 128 keeps chroma sums non-negative
  assign y_sum = r16 * 16'd66 + g16 * 16'd129 + b16 * 16'd25 + 16'd128;
  assign u_sum = b16 * 16'd112 + 16'd32896 - r16 * 16'd38 - g16 * 16'd74;
  assign v_sum = r16 * 16'd112 + 16'd32896 - g16 * 16'd94 - b16 * 16'd18;

  assign luma_o         = y_sum[15:8] + 8'd16;
  assign chroma_valid_o = pos_i.even_col;
  assign chroma_is_v_o  = pos_i.even_col & pos_i.odd_row;

  always_comb begin
    if (!pos_i.even_col) begin
      chroma_o = '0;
    end else if (pos_i.odd_row) begin
      chroma_o = v_sum[15:8];
    end else begin
      chroma_o = u_sum[15:8];
    end
  end

endmodule

/* design/rgb_to_yuv420_pixel_converter_top.sv */
// Top level of the RGB24 to YUV 4:2:0 pixel converter.
// Depends on rgb2yuv_pkg, rgb2yuv_pos and rgb2yuv_csc.
//
//   channel  | dir | payload
//   s_axis   | in  | tdata[23:0] = {blue, green, red}
//   m_axis   | out | tdata[15:0] = {chroma, luma}, tuser = {chroma_is_v, chroma_valid},
//            |     | tlast = end_of_frame
//   cfg      | in  | idx 0 frame_width, idx 1 frame_height
//
// One pixel per cycle sustained while m_axis does not stall; the input register and the
// result register sit around the conversion logic.
// Reset clears the counters, the valid flags and sets both frame sizes to 256.
// A stall on m_axis backs up through both registers before s_axis_tready_o drops.
`timescale 1ns / 1ps

module rgb_to_yuv420_pixel_converter_top #(
  parameter int MAX_WIDTH  = rgb2yuv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgb2yuv_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [23:0]                       s_axis_tdata_i,  // red, green, blue
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [15:0]                       m_axis_tdata_o,  // luma, chroma
  output logic [1:0]                        m_axis_tuser_o,  // chroma_valid, chroma_is_v
  output logic                              m_axis_tlast_o,
  input  logic                              cfg_we_i,
  input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import rgb2yuv_pkg::*;

  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic             in_xfer;
  logic             out_free;
  pos_t             pos;

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_red_q, s1_green_q, s1_blue_q;
  pos_t             s1_pos_q;

  logic [PIX_W-1:0] luma, chroma;
  logic             chroma_valid, chroma_is_v;

  logic             out_valid_q;
  logic [15:0]      out_data_q;
  logic [1:0]       out_user_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_SIZE_RESET;
      frame_height_q <= FRAME_SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign s_axis_tready_o = ~s1_valid_q | out_free;
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;

  rgb2yuv_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .advance_i     (in_xfer),
    .pos_o         (pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_red_q   <= s_axis_tdata_i[7:0];
      s1_green_q <= s_axis_tdata_i[15:8];
      s1_blue_q  <= s_axis_tdata_i[23:16];
      s1_pos_q   <= pos;
    end
  end

  rgb2yuv_csc u_csc (
    .red_i         (s1_red_q),
    .green_i       (s1_green_q),
    .blue_i        (s1_blue_q),
    .pos_i         (s1_pos_q),
    .luma_o        (luma),
    .chroma_valid_o(chroma_valid),
    .chroma_is_v_o (chroma_is_v),
    .chroma_o      (chroma)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_data_q <= {chroma, luma};
      out_user_q <= {chroma_is_v, chroma_valid};
      out_last_q <= s1_pos_q.end_of_frame;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* design/rgb2yuv_chk.sv */
// Port-level checker for the pixel converter, bound to its top level.
// Depends on rgb_to_yuv420_pixel_converter_top.
`timescale 1ns / 1ps

module rgb2yuv_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [15:0] m_tdata_i,
  input logic [1:0]  m_tuser_i,
  input logic        m_tlast_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i) && $stable(m_tuser_i)
      && $stable(m_tlast_i))
    else $error("result changed while stalled");

  a_v_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i[1] |-> m_tuser_i[0])
    else $error("V flagged on a pixel without chroma");

  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tuser_i[0] |-> m_tdata_i[15:8] == 8'd0)
    else $error("chroma nonzero on odd column");

  a_luma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[7:0] >= 8'd16 && m_tdata_i[7:0] <= 8'd235)
    else $error("luma out of range");

endmodule

bind rgb_to_yuv420_pixel_converter_top rgb2yuv_chk u_rgb2yuv_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tdata_i (m_axis_tdata_o),
  .m_tuser_i (m_axis_tuser_o),
  .m_tlast_i (m_axis_tlast_o)
);
